// File: hdl/fcik_pkg.sv
package fcik_pkg;

    // default coordinate width, 1/256 mm units
    localparam int COORD_BITS = 24;

    // sqrt(2) in Q16
    localparam int          RT2_BITS = 17;
    localparam logic [16:0] RT2_Q16  = 17'd92682;

    // register indexes
    localparam int          CFG_ADDR_BITS = 3;
    localparam logic [2:0]  REG_RADIUS    = 3'd0;
    localparam logic [2:0]  REG_PIVOT     = 3'd1;
    localparam logic [2:0]  REG_FWIDTH    = 3'd2;
    localparam logic [2:0]  REG_FDEPTH    = 3'd3;
    localparam logic [2:0]  REG_FHEIGHT   = 3'd4;
    localparam logic [2:0]  REG_BWIDTH    = 3'd5;
    localparam logic [2:0]  REG_BDEPTH    = 3'd6;

    localparam int          NUM_CABLES = 4;
    localparam logic [1:0]  CABLE_LAST = 2'd3;

    // tag that travels with every cable beat through the pipe
    typedef struct packed {
        logic       vld;
        logic [1:0] idx;
    } t_tag;

endpackage

// File: hdl/fcik_dist.sv
// clamp, cable offsets, squares and sum of squares: four register stages
module fcik_dist #(
    parameter int CW = fcik_pkg::COORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  fcik_pkg::t_tag       i_tag,
    input  logic [CW-1:0]        i_x,
    input  logic [CW-1:0]        i_y,
    input  logic [CW-1:0]        i_z,
    input  logic signed [CW+1:0] i_ext_x,
    input  logic signed [CW+1:0] i_ext_y,
    input  logic [CW-1:0]        i_hz,
    input  logic signed [CW+2:0] i_ux,
    input  logic signed [CW+2:0] i_uy,
    output fcik_pkg::t_tag       o_tag,
    output logic [2*CW+7:0]      o_sum
);

    localparam int PW = CW + 3;
    localparam int DW = CW + 4;
    localparam int MW = CW + 3;
    localparam int SQ = 2 * MW;
    localparam int SW = SQ + 2;

    function automatic logic signed [PW-1:0] clamp_lit(
        input logic signed [PW-1:0] v,
        input logic signed [PW-1:0] lo,
        input logic signed [PW-1:0] hi
    );
        logic signed [PW-1:0] t;
        t = (v < hi) ? v : hi;
        return (t > lo) ? t : lo;
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] a;
        a = (v < 0) ? -v : v;
        return a[MW-1:0];
    endfunction

    fcik_pkg::t_tag r_t1, r_t2, r_t3, r_t4;

    // stage 1: clamp
    logic signed [PW-1:0] w_vx, w_vy, w_hx, w_hy;
    logic signed [CW:0]   w_zs, w_hzs, w_zt, w_zp, w_zd;
    logic signed [PW-1:0] r_px2, r_py2;
    logic [CW:0]          r_dz2;

    assign w_vx  = $signed({{2{i_x[CW-1]}}, i_x, 1'b0});
    assign w_vy  = $signed({{2{i_y[CW-1]}}, i_y, 1'b0});
    assign w_hx  = $signed({i_ext_x[CW+1], i_ext_x});
    assign w_hy  = $signed({i_ext_y[CW+1], i_ext_y});
    assign w_zs  = $signed({i_z[CW-1], i_z});
    assign w_hzs = $signed({1'b0, i_hz});
    assign w_zt  = (w_zs < w_hzs) ? w_zs : w_hzs;
    assign w_zp  = (w_zt > 0) ? w_zt : '0;
    assign w_zd  = w_hzs - w_zp;

    // stage 2: offsets to the tower, magnitudes
    logic signed [DW-1:0] w_dx, w_dy;
    logic [MW-1:0]        r_ax, r_ay, r_az;
    logic                 w_sx_pos, w_sy_pos;

    // tower order (-,+) (+,+) (+,-) (-,-)
    assign w_sx_pos = (r_t1.idx == 2'd1) || (r_t1.idx == 2'd2);
    assign w_sy_pos = (r_t1.idx == 2'd0) || (r_t1.idx == 2'd1);
    assign w_dx = w_sx_pos ? ($signed({r_px2[PW-1], r_px2}) + $signed({i_ux[PW-1], i_ux}))
                           : ($signed({r_px2[PW-1], r_px2}) - $signed({i_ux[PW-1], i_ux}));
    assign w_dy = w_sy_pos ? ($signed({r_py2[PW-1], r_py2}) + $signed({i_uy[PW-1], i_uy}))
                           : ($signed({r_py2[PW-1], r_py2}) - $signed({i_uy[PW-1], i_uy}));

    // stage 3/4: squares, sum
    logic [SQ-1:0] r_qx, r_qy, r_qz;
    logic [SW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
        end else if (i_en) begin
            r_t1 <= i_tag;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px2 <= clamp_lit(w_vx, -w_hx, w_hx);
            r_py2 <= clamp_lit(w_vy, -w_hy, w_hy);
            r_dz2 <= {w_zd[CW-1:0], 1'b0};
            r_ax  <= mag(w_dx);
            r_ay  <= mag(w_dy);
            r_az  <= MW'(r_dz2);
            r_qx  <= r_ax * r_ax;
            r_qy  <= r_ay * r_ay;
            r_qz  <= r_az * r_az;
            r_sum <= SW'(r_qx) + SW'(r_qy) + SW'(r_qz);
        end
    end

    assign o_tag = r_t4;
    assign o_sum = r_sum;

endmodule

// File: hdl/fcik_isqrt.sv
// floor square root, one result bit per register stage
module fcik_isqrt #(
    parameter int SW = 56
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  fcik_pkg::t_tag   i_tag,
    input  logic [SW-1:0]    i_val,
    output fcik_pkg::t_tag   o_tag,
    output logic [SW/2-1:0]  o_root
);

    localparam int RW = SW / 2;

    fcik_pkg::t_tag     r_tag  [RW];
    logic [SW:0]        r_rem  [RW];
    logic [RW-1:0]      r_root [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int B = RW - 1 - j;
        fcik_pkg::t_tag w_tag_in;
        logic [SW:0]    w_rem_in, w_diff;
        logic [RW-1:0]  w_root_in;

        if (j == 0) begin : g_first
            assign w_tag_in  = i_tag;
            assign w_rem_in  = {1'b0, i_val};
            assign w_root_in = '0;
        end else begin : g_next
            assign w_tag_in  = r_tag[j-1];
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
        end

        // (root + 2^B)^2 - root^2
        assign w_diff = ((SW+1)'(w_root_in) << (B + 1)) + ((SW+1)'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[j] <= '0;
            end else if (i_en) begin
                r_tag[j] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_diff <= w_rem_in) begin
                    r_rem[j]  <= w_rem_in - w_diff;
                    r_root[j] <= w_root_in | (RW'(1) << B);
                end else begin
                    r_rem[j]  <= w_rem_in;
                    r_root[j] <= w_root_in;
                end
            end
        end
    end

    assign o_tag  = r_tag[RW-1];
    assign o_root = r_root[RW-1];

endmodule

// File: hdl/four_cable_inverse_kinematics_top.sv
// Beats pass the holding register, distance pipe, square-root pipe and output register.
// The four cables of a pose share one pipe, one cable a cycle while the pipe advances.
// The whole pipe holds while a finished beat waits on the output side.
// Reset: synchronous, active low; clears valid bits and config registers to 0.
// Config writes reach the pipe through the registered derived-config terms.
module four_cable_inverse_kinematics_top #(
    parameter int COORD_BITS = fcik_pkg::COORD_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // target_x, target_y, target_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]       i_s_tdata,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // length_0, length_1, length_2, length_3
    output logic [((4*(COORD_BITS+1)+7)/8)*8-1:0]   o_m_tdata,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    input  logic                                    i_cfg_we,
    input  logic [fcik_pkg::CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  logic [COORD_BITS-1:0]                   i_cfg_data
);

    localparam int CW  = COORD_BITS;
    localparam int MW  = CW + 3;
    localparam int SW  = 2 * MW + 2;
    localparam int RW  = SW / 2;
    localparam int LW  = CW + 1;
    localparam int ODW = ((4 * LW + 7) / 8) * 8;
    localparam int PRW = CW + fcik_pkg::RT2_BITS;

    // config registers
    logic [CW-1:0] r_radius, r_pivot, r_fwidth, r_fdepth, r_fheight, r_bwidth, r_bdepth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= '0;
            r_pivot   <= '0;
            r_fwidth  <= '0;
            r_fdepth  <= '0;
            r_fheight <= '0;
            r_bwidth  <= '0;
            r_bdepth  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fcik_pkg::REG_RADIUS:  r_radius  <= i_cfg_data;
                fcik_pkg::REG_PIVOT:   r_pivot   <= i_cfg_data;
                fcik_pkg::REG_FWIDTH:  r_fwidth  <= i_cfg_data;
                fcik_pkg::REG_FDEPTH:  r_fdepth  <= i_cfg_data;
                fcik_pkg::REG_FHEIGHT: r_fheight <= i_cfg_data;
                fcik_pkg::REG_BWIDTH:  r_bwidth  <= i_cfg_data;
                fcik_pkg::REG_BDEPTH:  r_bdepth  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived config: extents in 1/512 mm, sqrt(2)*radius, radius-minus-frame terms
    logic signed [CW+1:0] w_fx, w_fy, w_bx, w_by, r_ext_x, r_ext_y;
    logic [PRW-1:0]       w_prod;
    logic [CW+1:0]        r_ra;
    logic signed [CW+2:0] r_ux, r_uy;

    assign w_fx   = $signed({2'b00, r_fwidth}) - $signed({1'b0, r_pivot, 1'b0});
    assign w_fy   = $signed({2'b00, r_fdepth}) - $signed({1'b0, r_pivot, 1'b0});
    assign w_bx   = $signed({2'b00, r_bwidth});
    assign w_by   = $signed({2'b00, r_bdepth});
    assign w_prod = PRW'(r_radius) * PRW'(fcik_pkg::RT2_Q16);

    always_ff @(posedge i_clk) begin
        r_ext_x <= (w_bx < w_fx) ? w_bx : w_fx;
        r_ext_y <= (w_by < w_fy) ? w_by : w_fy;
        r_ra    <= w_prod[PRW-1:15];
        r_ux    <= $signed({1'b0, r_ra}) - $signed({3'b000, r_fwidth});
        r_uy    <= $signed({1'b0, r_ra}) - $signed({3'b000, r_fdepth});
    end

    // pipe advances unless a finished beat is stuck at the output
    logic w_adv;
    logic r_ovld;
    assign w_adv = !r_ovld || i_m_tready;

    // pose holding register, issues one cable per cycle while the pipe advances
    logic          r_hvld;
    logic [1:0]    r_k;
    logic [CW-1:0] r_hx, r_hy, r_hz;
    logic          w_s_acc;

    assign o_s_tready = w_adv && (!r_hvld || r_k == fcik_pkg::CABLE_LAST);
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld <= 1'b0;
            r_k    <= '0;
        end else if (w_adv) begin
            if (w_s_acc) begin
                r_hvld <= 1'b1;
                r_k    <= '0;
            end else if (r_hvld) begin
                r_k <= r_k + 2'd1;
                if (r_k == fcik_pkg::CABLE_LAST) begin
                    r_hvld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_hx <= i_s_tdata[CW-1:0];
            r_hy <= i_s_tdata[2*CW-1:CW];
            r_hz <= i_s_tdata[3*CW-1:2*CW];
        end
    end

    fcik_pkg::t_tag w_issue, w_dtag, w_rtag;
    logic [SW-1:0]  w_sum;
    logic [RW-1:0]  w_root;

    assign w_issue.vld = r_hvld;
    assign w_issue.idx = r_k;

    fcik_dist #(.CW(CW)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_tag   (w_issue),
        .i_x     (r_hx),
        .i_y     (r_hy),
        .i_z     (r_hz),
        .i_ext_x (r_ext_x),
        .i_ext_y (r_ext_y),
        .i_hz    (r_fheight),
        .i_ux    (r_ux),
        .i_uy    (r_uy),
        .o_tag   (w_dtag),
        .o_sum   (w_sum)
    );

    fcik_isqrt #(.SW(SW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_tag   (w_dtag),
        .i_val   (w_sum),
        .o_tag   (w_rtag),
        .o_root  (w_root)
    );

    // halve to 1/256 mm, remove pivot offset, floor at 0, saturate
    logic [RW-2:0] w_d, w_diff;
    logic [LW-1:0] w_len;

    assign w_d    = w_root[RW-1:1];
    assign w_diff = (w_d > (RW-1)'(r_pivot)) ? (w_d - (RW-1)'(r_pivot)) : '0;
    assign w_len  = (w_diff[RW-2:LW] != '0) ? '1 : w_diff[LW-1:0];

    // collect the four cables into one output beat
    logic [LW-1:0]  r_len0, r_len1, r_len2;
    logic [ODW-1:0] r_odata;

    always_ff @(posedge i_clk) begin
        if (w_adv && w_rtag.vld) begin
            case (w_rtag.idx)
                2'd0:    r_len0 <= w_len;
                2'd1:    r_len1 <= w_len;
                2'd2:    r_len2 <= w_len;
                default: r_odata <= ODW'({w_len, r_len2, r_len1, r_len0});
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_ovld <= w_rtag.vld && (w_rtag.idx == fcik_pkg::CABLE_LAST);
        end
    end

    assign o_m_tdata  = r_odata;
    assign o_m_tvalid = r_ovld;

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !i_m_tready) |=> (r_ovld && $stable(r_odata)))
        else $error("output beat lost during stall");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_hvld && r_k == 2'd0))
        else $error("accepted pose not issued from first cable");

    a_ready_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hvld && r_k != fcik_pkg::CABLE_LAST) |-> !o_s_tready)
        else $error("ready raised mid pose");

    a_cable_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_rtag.vld && w_rtag.idx != fcik_pkg::CABLE_LAST)
            |=> (w_rtag.vld && w_rtag.idx == $past(w_rtag.idx) + 2'd1))
        else $error("cable beats out of order at pipe exit");
`endif

endmodule
